FILE: sv/zcpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcpa_pkg
// Shared types and constants of the zero-crossing half-period analyzer:
// register indexes, limit register layout, class and slope codes.
// ----------------------------------------------------------------------------
package zcpa_pkg;

	localparam int LIMIT_W      = 20;
	localparam int JUMP_LIMIT_W = 16;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 20;
	localparam int COUNT_W      = 32;
	localparam int CLASS_W      = 3;
	localparam int DIR_W        = 2;

	localparam logic [LIMIT_W-1:0]      ULTRA_SHORT_RST = LIMIT_W'(40);
	localparam logic [LIMIT_W-1:0]      SHORT_RST       = LIMIT_W'(400);
	localparam logic [LIMIT_W-1:0]      LONG_RST        = LIMIT_W'(600);
	localparam logic [LIMIT_W-1:0]      ULTRA_LONG_RST  = LIMIT_W'(800);
	localparam logic [JUMP_LIMIT_W-1:0] JUMP_RST        = JUMP_LIMIT_W'(450);

	// Register indexes on the config port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ULTRA_SHORT = 3'd0,
		REG_SHORT       = 3'd1,
		REG_LONG        = 3'd2,
		REG_ULTRA_LONG  = 3'd3,
		REG_JUMP        = 3'd4
	} cfg_reg_t;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_NORMAL      = 3'd0,
		CLASS_ULTRA_SHORT = 3'd1,
		CLASS_SHORT       = 3'd2,
		CLASS_ULTRA_LONG  = 3'd3,
		CLASS_LONG        = 3'd4
	} period_class_t;

	// Slope direction, two's complement: -1 falling, 0 unknown, +1 rising
	localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'b00;
	localparam logic [DIR_W-1:0] DIR_RISING  = 2'b01;
	localparam logic [DIR_W-1:0] DIR_FALLING = 2'b11;

	typedef struct packed {
		logic [LIMIT_W-1:0]      ultra_short;
		logic [LIMIT_W-1:0]      short_lim;
		logic [LIMIT_W-1:0]      long_lim;
		logic [LIMIT_W-1:0]      ultra_long;
		logic [JUMP_LIMIT_W-1:0] jump;
	} limits_t;

endpackage
`default_nettype wire

FILE: sv/zero_crossing_period_analyzer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zero_crossing_period_analyzer_core
// Zero-crossing half-period analyzer with slope, peak and jump tracking.
// ----------------------------------------------------------------------------
// Takes one sample per clock and returns one result word per sample: the
// sample is held in an input register, the tracking logic works on it in one
// pass and the result lands in an output register. Input and output are
// parted by those two registers, so the input keeps flowing while a result
// waits; in_ready drops only when both hold a word and out_ready is low.
// Limits are to be written through the config port only while no sample is
// in flight, unenforced by the block; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module zero_crossing_period_analyzer_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int PERIOD_WIDTH = 20
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [zcpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [zcpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     sample,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    crossing,
	output logic [PERIOD_WIDTH-1:0]                 half_period,
	output logic [zcpa_pkg::CLASS_W-1:0]            period_class,
	output logic signed [zcpa_pkg::DIR_W-1:0]       direction,
	output logic signed [SAMPLE_WIDTH-1:0]          min_seen,
	output logic [SAMPLE_WIDTH-2:0]                 max_seen,
	output logic signed [SAMPLE_WIDTH-1:0]          sample_two_back,
	output logic signed [SAMPLE_WIDTH-1:0]          sample_one_back,
	output logic                                    jump,
	output logic [SAMPLE_WIDTH-1:0]                 jump_size,
	output logic [zcpa_pkg::COUNT_W-1:0]            crossing_count,
	output logic [zcpa_pkg::COUNT_W-1:0]            filtered_total
);

	zcpa_pkg::limits_t limits;

	logic                           valid_s1, valid_s2;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           advance;

	logic                           r_crossing, r_jump;
	logic [PERIOD_WIDTH-1:0]        r_half;
	logic [zcpa_pkg::CLASS_W-1:0]   r_class;
	logic [zcpa_pkg::DIR_W-1:0]     r_dir;
	logic signed [SAMPLE_WIDTH-1:0] r_min, r_two, r_one;
	logic [SAMPLE_WIDTH-2:0]        r_max;
	logic [SAMPLE_WIDTH-1:0]        r_jsize;
	logic [zcpa_pkg::COUNT_W-1:0]   r_count, r_total;

	logic                           crossing_s2, jump_s2;
	logic [PERIOD_WIDTH-1:0]        half_s2;
	logic [zcpa_pkg::CLASS_W-1:0]   class_s2;
	logic [zcpa_pkg::DIR_W-1:0]     dir_s2;
	logic signed [SAMPLE_WIDTH-1:0] min_s2, two_s2, one_s2;
	logic [SAMPLE_WIDTH-2:0]        max_s2;
	logic [SAMPLE_WIDTH-1:0]        jsize_s2;
	logic [zcpa_pkg::COUNT_W-1:0]   count_s2, total_s2;

	assign cfg_ready = 1'b1;

	zcpa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	// the input word moves on when the output register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_s1 <= sample;
	end

	zcpa_track #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.PERIOD_WIDTH (PERIOD_WIDTH)
	) u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.sample_in       (sample_s1),
		.limits          (limits),
		.res_crossing    (r_crossing),
		.res_half_period (r_half),
		.res_class       (r_class),
		.res_direction   (r_dir),
		.res_min         (r_min),
		.res_max         (r_max),
		.res_two_back    (r_two),
		.res_one_back    (r_one),
		.res_jump        (r_jump),
		.res_jump_size   (r_jsize),
		.res_cross_count (r_count),
		.res_total       (r_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			crossing_s2 <= r_crossing;
			half_s2     <= r_half;
			class_s2    <= r_class;
			dir_s2      <= r_dir;
			min_s2      <= r_min;
			max_s2      <= r_max;
			two_s2      <= r_two;
			one_s2      <= r_one;
			jump_s2     <= r_jump;
			jsize_s2    <= r_jsize;
			count_s2    <= r_count;
			total_s2    <= r_total;
		end
	end

	assign out_valid       = valid_s2;
	assign crossing        = crossing_s2;
	assign half_period     = half_s2;
	assign period_class    = class_s2;
	assign direction       = dir_s2;
	assign min_seen        = min_s2;
	assign max_seen        = max_s2;
	assign sample_two_back = two_s2;
	assign sample_one_back = one_s2;
	assign jump            = jump_s2;
	assign jump_size       = jsize_s2;
	assign crossing_count  = count_s2;
	assign filtered_total  = total_s2;

endmodule
`default_nettype wire

FILE: sv/zcpa_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcpa_cfg_regs
// Limit registers behind the config write port. Unknown indexes are dropped.
// ----------------------------------------------------------------------------
module zcpa_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	input  wire logic [zcpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [zcpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	output zcpa_pkg::limits_t                       limits
);

	zcpa_pkg::limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.ultra_short <= zcpa_pkg::ULTRA_SHORT_RST;
			limits_q.short_lim   <= zcpa_pkg::SHORT_RST;
			limits_q.long_lim    <= zcpa_pkg::LONG_RST;
			limits_q.ultra_long  <= zcpa_pkg::ULTRA_LONG_RST;
			limits_q.jump        <= zcpa_pkg::JUMP_RST;
		end else if (cfg_valid) begin
			unique case (zcpa_pkg::cfg_reg_t'(cfg_index))
				zcpa_pkg::REG_ULTRA_SHORT: limits_q.ultra_short <= cfg_data;
				zcpa_pkg::REG_SHORT:       limits_q.short_lim   <= cfg_data;
				zcpa_pkg::REG_LONG:        limits_q.long_lim    <= cfg_data;
				zcpa_pkg::REG_ULTRA_LONG:  limits_q.ultra_long  <= cfg_data;
				zcpa_pkg::REG_JUMP: begin
					limits_q.jump <= cfg_data[zcpa_pkg::JUMP_LIMIT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign limits = limits_q;

endmodule
`default_nettype wire

FILE: sv/zcpa_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcpa_track
// Per-sample tracking state (history, slope, peaks, counters) and the
// single-pass logic that turns one sample into one result word.
// ----------------------------------------------------------------------------
module zcpa_track #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int PERIOD_WIDTH = 20
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                advance,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	input  zcpa_pkg::limits_t                        limits,
	output logic                                     res_crossing,
	output logic [PERIOD_WIDTH-1:0]                  res_half_period,
	output logic [zcpa_pkg::CLASS_W-1:0]             res_class,
	output logic [zcpa_pkg::DIR_W-1:0]               res_direction,
	output logic signed [SAMPLE_WIDTH-1:0]           res_min,
	output logic [SAMPLE_WIDTH-2:0]                  res_max,
	output logic signed [SAMPLE_WIDTH-1:0]           res_two_back,
	output logic signed [SAMPLE_WIDTH-1:0]           res_one_back,
	output logic                                     res_jump,
	output logic [SAMPLE_WIDTH-1:0]                  res_jump_size,
	output logic [zcpa_pkg::COUNT_W-1:0]             res_cross_count,
	output logic [zcpa_pkg::COUNT_W-1:0]             res_total
);

	localparam int CMP_W  = (PERIOD_WIDTH > zcpa_pkg::LIMIT_W) ? PERIOD_WIDTH
		: zcpa_pkg::LIMIT_W;
	localparam int JCMP_W = (SAMPLE_WIDTH > zcpa_pkg::JUMP_LIMIT_W) ? SAMPLE_WIDTH
		: zcpa_pkg::JUMP_LIMIT_W;

	logic signed [SAMPLE_WIDTH-1:0] last_q, older_q, low_q;
	logic [SAMPLE_WIDTH-2:0]        high_q;
	logic [zcpa_pkg::DIR_W-1:0]     dir_q;
	logic [PERIOD_WIDTH-1:0]        since_q;
	logic [1:0]                     warm_q;
	logic [zcpa_pkg::COUNT_W-1:0]   count_q, sum_q;

	logic [zcpa_pkg::DIR_W-1:0]     dir_nxt;
	logic signed [SAMPLE_WIDTH-1:0] low_nxt;
	logic [SAMPLE_WIDTH-2:0]        high_nxt;
	logic [PERIOD_WIDTH-1:0]        since_inc;
	logic                           cross_hit;
	logic [CMP_W-1:0]               half_ext;
	zcpa_pkg::period_class_t        cls;
	logic [zcpa_pkg::COUNT_W:0]     sum_add;
	logic [zcpa_pkg::COUNT_W-1:0]   sum_nxt, count_nxt;
	logic signed [SAMPLE_WIDTH:0]   diff;
	logic [SAMPLE_WIDTH:0]          diff_abs;
	logic [SAMPLE_WIDTH-1:0]        jsize;

	always_comb begin
		dir_nxt = dir_q;
		if (sample_in > last_q)
			dir_nxt = zcpa_pkg::DIR_RISING;
		else if (sample_in < last_q)
			dir_nxt = zcpa_pkg::DIR_FALLING;

		// peaks move only in the direction of the slope
		high_nxt = high_q;
		low_nxt  = low_q;
		if (dir_nxt == zcpa_pkg::DIR_RISING
				&& $signed({1'b0, high_q}) < sample_in)
			high_nxt = sample_in[SAMPLE_WIDTH-2:0];
		else if (dir_nxt == zcpa_pkg::DIR_FALLING && low_q > sample_in)
			low_nxt = sample_in;

		since_inc = (since_q == '1) ? since_q : since_q + 1'b1;

		cross_hit = warm_q[1] && ((last_q < 0 && sample_in > 0)
			|| (last_q > 0 && sample_in < 0));

		half_ext = CMP_W'(since_inc);
		if (half_ext < CMP_W'(limits.ultra_short))
			cls = zcpa_pkg::CLASS_ULTRA_SHORT;
		else if (half_ext < CMP_W'(limits.short_lim))
			cls = zcpa_pkg::CLASS_SHORT;
		else if (half_ext > CMP_W'(limits.ultra_long))
			cls = zcpa_pkg::CLASS_ULTRA_LONG;
		else if (half_ext > CMP_W'(limits.long_lim))
			cls = zcpa_pkg::CLASS_LONG;
		else
			cls = zcpa_pkg::CLASS_NORMAL;

		sum_add = {1'b0, sum_q} + (zcpa_pkg::COUNT_W + 1)'(since_inc);
		sum_nxt = sum_q;
		if (cross_hit && cls == zcpa_pkg::CLASS_NORMAL)
			sum_nxt = sum_add[zcpa_pkg::COUNT_W] ? '1 : sum_add[zcpa_pkg::COUNT_W-1:0];

		count_nxt = count_q;
		if (cross_hit && count_q != '1)
			count_nxt = count_q + 1'b1;

		diff     = {sample_in[SAMPLE_WIDTH-1], sample_in} - {last_q[SAMPLE_WIDTH-1], last_q};
		diff_abs = diff[SAMPLE_WIDTH] ? (~diff + 1'b1) : diff;
		jsize    = diff_abs[SAMPLE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			older_q <= '0;
			dir_q   <= zcpa_pkg::DIR_UNKNOWN;
			high_q  <= '0;
			low_q   <= '0;
			since_q <= '0;
			warm_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (advance) begin
			last_q  <= sample_in;
			older_q <= last_q;
			dir_q   <= dir_nxt;
			// the extreme on the side just entered is cleared at a crossing
			high_q  <= (cross_hit && dir_nxt == zcpa_pkg::DIR_RISING) ? '0 : high_nxt;
			low_q   <= (cross_hit && dir_nxt == zcpa_pkg::DIR_FALLING) ? '0 : low_nxt;
			since_q <= cross_hit ? '0 : since_inc;
			if (!warm_q[1])
				warm_q <= warm_q + 1'b1;
			count_q <= count_nxt;
			sum_q   <= sum_nxt;
		end
	end

	assign res_crossing    = cross_hit;
	assign res_half_period = cross_hit ? since_inc : '0;
	assign res_class       = cross_hit ? cls : zcpa_pkg::CLASS_NORMAL;
	assign res_direction   = dir_nxt;
	assign res_min         = low_nxt;
	assign res_max         = high_nxt;
	assign res_two_back    = older_q;
	assign res_one_back    = last_q;
	assign res_jump        = JCMP_W'(jsize) > JCMP_W'(limits.jump);
	assign res_jump_size   = jsize;
	assign res_cross_count = count_nxt;
	assign res_total       = sum_nxt;

endmodule
`default_nettype wire

FILE: sv/zcpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcpa_checker
// Port-level checks of the analyzer, bound to the top level.
// ----------------------------------------------------------------------------
module zcpa_checker #(
	parameter int PERIOD_WIDTH = 20
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic                             crossing,
	input wire logic [PERIOD_WIDTH-1:0]          half_period,
	input wire logic [zcpa_pkg::CLASS_W-1:0]     period_class,
	input wire logic [zcpa_pkg::COUNT_W-1:0]     crossing_count
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(half_period)
			&& $stable(crossing_count))
		else $error("stalled result word changed");

	// input never stalls while the output side is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// no crossing: no half-period and no class
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !crossing |-> half_period == '0
			&& period_class == zcpa_pkg::CLASS_NORMAL)
		else $error("period reported without crossing");

	// a crossing always has a nonzero count and a nonzero half-period
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crossing |-> crossing_count != '0 && half_period != '0)
		else $error("crossing word with zero count or length");

endmodule

bind zero_crossing_period_analyzer_core zcpa_checker #(
	.PERIOD_WIDTH (PERIOD_WIDTH)
) u_zcpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.crossing       (crossing),
	.half_period    (half_period),
	.period_class   (period_class),
	.crossing_count (crossing_count)
);
`default_nettype wire
